### rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset.
`define JSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define JSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/jsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jsd_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int STEP_BITS     = 14;
   localparam int DZ_BITS       = SAMPLE_BITS - 1;
   localparam int TGT_BITS      = STEP_BITS + 4;
   localparam int UNIT_BITS     = STEP_BITS - 7;
   localparam int ARC_BITS      = 4;
   localparam int H_BITS        = UNIT_BITS + ARC_BITS;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = (STEP_BITS > SAMPLE_BITS) ? STEP_BITS : SAMPLE_BITS;

   typedef enum logic [1:0] {
      DIR_STAY = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_STEPS_PER_REV = 3'd0,
      REG_MIDDLE_X      = 3'd1,
      REG_MIDDLE_Y      = 3'd2,
      REG_DEAD_ZONE     = 3'd3,
      REG_NOISE_TOL     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [STEP_BITS-1:0]   steps_per_rev;
      logic [SAMPLE_BITS-1:0] middle_x;
      logic [SAMPLE_BITS-1:0] middle_y;
      logic [DZ_BITS-1:0]     dead_zone;
      logic [STEP_BITS-1:0]   noise_tol;
   } cfg_type;

   // Sideband that rides along the divider.
   typedef struct packed {
      logic                 centred;
      logic                 use_axis;
      logic                 add_h;
      logic [STEP_BITS-1:0] axis;
      logic [STEP_BITS-1:0] base;
      logic [STEP_BITS-1:0] pos;
   } ctx_type;

   typedef struct packed {
      logic                   valid;
      ctx_type                ctx;
      logic [SAMPLE_BITS-1:0] num;
      logic [SAMPLE_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                   valid;
      ctx_type                ctx;
      logic [SAMPLE_BITS-1:0] quo;
      logic [SAMPLE_BITS-1:0] rem;
      logic [SAMPLE_BITS-1:0] den;
   } div_rsp_type;

   typedef struct packed {
      logic                       valid;
      ctx_type                    ctx;
      logic signed [TGT_BITS-1:0] tgt;
   } tgt_type;

   // Piecewise arctangent in table units.
   function automatic logic [ARC_BITS-1:0] arc_units(
      input logic [SAMPLE_BITS-1:0] q,
      input logic [SAMPLE_BITS-1:0] r,
      input logic [SAMPLE_BITS-1:0] d
   );
      logic [SAMPLE_BITS:0]   r_ext;
      logic [SAMPLE_BITS:0]   sixteenth;
      logic [SAMPLE_BITS:0]   fourth;
      logic [SAMPLE_BITS:0]   eighth;
      logic [ARC_BITS-1:0]    res;
      r_ext     = {1'b0, r};
      sixteenth = {5'd0, d[SAMPLE_BITS-1:4]};
      fourth    = {3'd0, d[SAMPLE_BITS-1:2]};
      eighth    = {4'd0, d[SAMPLE_BITS-1:3]};
      if (q >= SAMPLE_BITS'(20))                            res = 4'd15;
      else if (q >= SAMPLE_BITS'(10))                       res = 4'd14;
      else if (q >= SAMPLE_BITS'(6))                        res = 4'd13;
      else if (q >= SAMPLE_BITS'(5))                        res = 4'd12;
      else if (q >= SAMPLE_BITS'(4))                        res = 4'd11;
      else if (q >= SAMPLE_BITS'(3) && r_ext >= sixteenth)  res = 4'd10;
      else if (q >= SAMPLE_BITS'(2) && r_ext >= sixteenth + fourth) res = 4'd9;
      else if (q >= SAMPLE_BITS'(2) && r_ext >= sixteenth)  res = 4'd8;
      else if (q >= SAMPLE_BITS'(2))                        res = 4'd7;
      else if (r_ext >= fourth + sixteenth + eighth)        res = 4'd6;
      else if (r_ext >= fourth + sixteenth)                 res = 4'd5;
      else if (r_ext >= fourth)                             res = 4'd4;
      else if (r_ext >= sixteenth)                          res = 4'd3;
      else if (r_ext >= eighth)                             res = 4'd2;
      else                                                  res = 4'd1;
      return res;
   endfunction

endpackage
`default_nettype wire

### rtl/core/jsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module jsd_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic [jsd_pkg::SAMPLE_BITS-1:0] sample_x,
   input  wire logic [jsd_pkg::SAMPLE_BITS-1:0] sample_y,
   input  wire logic [jsd_pkg::STEP_BITS-1:0]   current_step,
   input  jsd_pkg::cfg_type                     cfg,
   output jsd_pkg::div_req_type                 out
);
   import jsd_pkg::*;

   logic signed [SAMPLE_BITS:0] x_diff, y_diff, x_neg, y_neg;
   logic [SAMPLE_BITS-1:0] mag_x, mag_y, dz;
   logic [STEP_BITS-1:0]   n, half, quarter, eighth, axis_x, axis_y;
   logic                   nx, ny, flip, b_small, a_small, a_ge_b;
   div_req_type            out_ff, out_in;

   always_comb begin
      x_diff  = $signed({1'b0, sample_x}) - $signed({1'b0, cfg.middle_x});
      y_diff  = $signed({1'b0, sample_y}) - $signed({1'b0, cfg.middle_y});
      x_neg   = -x_diff;
      y_neg   = -y_diff;
      nx      = x_diff[SAMPLE_BITS];
      ny      = y_diff[SAMPLE_BITS];
      mag_x   = nx ? x_neg[SAMPLE_BITS-1:0] : x_diff[SAMPLE_BITS-1:0];
      mag_y   = ny ? y_neg[SAMPLE_BITS-1:0] : y_diff[SAMPLE_BITS-1:0];
      dz      = {1'b0, cfg.dead_zone};
      n       = cfg.steps_per_rev;
      half    = n >> 1;
      quarter = n >> 2;
      eighth  = n >> 3;
      out_in  = '0;
      out_in.valid   = in_valid;
      out_in.ctx.pos = current_step;
      // pick the quadrant; X is tested first with zero as non-negative
      if (!nx && !ny) begin
         axis_x = half;  axis_y = half + quarter; out_in.ctx.base = half + eighth; flip = 1'b0;
      end else if (!nx) begin
         axis_x = '0;    axis_y = half + quarter; out_in.ctx.base = n - eighth;    flip = 1'b1;
      end else if (ny || y_diff == '0) begin
         axis_x = '0;    axis_y = quarter;        out_in.ctx.base = eighth;        flip = 1'b0;
      end else begin
         axis_x = half;  axis_y = quarter;        out_in.ctx.base = half - eighth; flip = 1'b1;
      end
      b_small = mag_x <= dz;
      a_small = mag_y <= dz;
      a_ge_b  = mag_y >= mag_x;
      out_in.ctx.centred  = a_small && b_small;
      out_in.ctx.use_axis = a_small || b_small;
      out_in.ctx.axis     = b_small ? axis_x : axis_y;
      out_in.ctx.add_h    = a_ge_b ? flip : !flip;
      out_in.num          = a_ge_b ? mag_y : mag_x;
      out_in.den          = a_ge_b ? mag_x : mag_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         out_ff.ctx <= out_in.ctx;
         out_ff.num <= out_in.num;
         out_ff.den <= out_in.den;
      end
   end

   assign out = out_ff;
endmodule
`default_nettype wire

### rtl/core/jsd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module jsd_div (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  jsd_pkg::div_req_type in,
   output jsd_pkg::div_rsp_type out
);
   import jsd_pkg::*;

   localparam int SB = SAMPLE_BITS;

   // one quotient bit per stage, restoring
   logic           v_ff   [1:SB];
   ctx_type        ctx_ff [1:SB];
   logic [SB-1:0]  num_ff [1:SB];
   logic [SB-1:0]  den_ff [1:SB];
   logic [SB-1:0]  rem_ff [1:SB];
   logic [SB-1:0]  quo_ff [1:SB];

   logic           v_src   [0:SB-1];
   ctx_type        ctx_src [0:SB-1];
   logic [SB-1:0]  num_src [0:SB-1];
   logic [SB-1:0]  den_src [0:SB-1];
   logic [SB-1:0]  rem_src [0:SB-1];
   logic [SB-1:0]  quo_src [0:SB-1];

   assign v_src[0]   = in.valid;
   assign ctx_src[0] = in.ctx;
   assign num_src[0] = in.num;
   assign den_src[0] = in.den;
   assign rem_src[0] = '0;
   assign quo_src[0] = '0;

   for (genvar k = 0; k < SB; k++) begin : g_stage
      logic [SB:0] part, diff;
      logic        ge;
      assign part = {rem_src[k], num_src[k][SB-1]};
      assign diff = part - {1'b0, den_src[k]};
      assign ge   = part >= {1'b0, den_src[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_src[k];
         end
         if (en) begin
            ctx_ff[k+1] <= ctx_src[k];
            den_ff[k+1] <= den_src[k];
            num_ff[k+1] <= {num_src[k][SB-2:0], 1'b0};
            rem_ff[k+1] <= ge ? diff[SB-1:0] : part[SB-1:0];
            quo_ff[k+1] <= {quo_src[k][SB-2:0], ge};
         end
      end

      if (k > 0) begin : g_link
         assign v_src[k]   = v_ff[k];
         assign ctx_src[k] = ctx_ff[k];
         assign num_src[k] = num_ff[k];
         assign den_src[k] = den_ff[k];
         assign rem_src[k] = rem_ff[k];
         assign quo_src[k] = quo_ff[k];
      end
   end

   assign out.valid = v_ff[SB];
   assign out.ctx   = ctx_ff[SB];
   assign out.quo   = quo_ff[SB];
   assign out.rem   = rem_ff[SB];
   assign out.den   = den_ff[SB];

   // shifted-out dividend bits are spent by the last stage
   logic unused_num;
   assign unused_num = ^num_ff[SB];
endmodule
`default_nettype wire

### rtl/core/jsd_target.sv
`timescale 1ns / 1ps
`default_nettype none
module jsd_target (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic [jsd_pkg::STEP_BITS-1:0] steps_per_rev,
   input  jsd_pkg::div_rsp_type               in,
   output jsd_pkg::tgt_type                   out
);
   import jsd_pkg::*;

   logic                 a_valid_ff, b_valid_ff;
   ctx_type              a_ctx_ff, b_ctx_ff;
   logic [ARC_BITS-1:0]  arc_ff;
   logic [H_BITS-1:0]    h_ff;
   logic [UNIT_BITS-1:0] unit;
   logic [H_BITS-1:0]    unit_ext, arc_ext;
   logic signed [TGT_BITS-1:0] base_s, axis_s, h_s;
   tgt_type              out_ff, out_in;

   assign unit     = steps_per_rev[STEP_BITS-1:7];
   assign unit_ext = {{(H_BITS-UNIT_BITS){1'b0}}, unit};
   assign arc_ext  = {{(H_BITS-ARC_BITS){1'b0}}, arc_ff};

   always_comb begin
      base_s = $signed({{(TGT_BITS-STEP_BITS){1'b0}}, b_ctx_ff.base});
      axis_s = $signed({{(TGT_BITS-STEP_BITS){1'b0}}, b_ctx_ff.axis});
      h_s    = $signed({{(TGT_BITS-H_BITS){1'b0}}, h_ff});
      out_in.valid = b_valid_ff;
      out_in.ctx   = b_ctx_ff;
      if (b_ctx_ff.centred)       out_in.tgt = '0;
      else if (b_ctx_ff.use_axis) out_in.tgt = axis_s;
      else if (b_ctx_ff.add_h)    out_in.tgt = base_s + h_s;
      else                        out_in.tgt = base_s - h_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= in.valid;
         b_valid_ff   <= a_valid_ff;
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         a_ctx_ff   <= in.ctx;
         arc_ff     <= arc_units(in.quo, in.rem, in.den);
         b_ctx_ff   <= a_ctx_ff;
         h_ff       <= unit_ext * arc_ext;
         out_ff.ctx <= out_in.ctx;
         out_ff.tgt <= out_in.tgt;
      end
   end

   assign out = out_ff;
endmodule
`default_nettype wire

### rtl/core/joystick_to_stepper_direction.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Ports                               Direction  Transfer when
// req      sample_x, sample_y, current_step    in         req_valid && req_ready
// rsp      direction, target_step              out        rsp_valid && rsp_ready
// csr      index, wdata                        in         csr_write_en
//
// One transfer in per cycle while req_ready is high; the pipeline has a front stage,
// one divider stage per quotient bit, three target stages and an output register.
// The divider pipeline sets the depth; every stage passes one item a cycle while en is high.
// Synchronous reset clears valid bits and loads the calibration defaults.
// A held result freezes the whole pipeline; req_ready drops only then.
module joystick_to_stepper_direction (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [jsd_pkg::SAMPLE_BITS-1:0]     req_sample_x,
   input  wire logic [jsd_pkg::SAMPLE_BITS-1:0]     req_sample_y,
   input  wire logic [jsd_pkg::STEP_BITS-1:0]       req_current_step,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [1:0]                          rsp_direction,
   output      logic [jsd_pkg::STEP_BITS-1:0]       rsp_target_step,
   input  wire logic                                csr_write_en,
   input  wire logic [jsd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [jsd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import jsd_pkg::*;

   cfg_type      cfg_ff;
   logic         en;
   div_req_type  front_out;
   div_rsp_type  div_out;
   tgt_type      tgt_out;

   logic                 rsp_valid_ff;
   dir_type              dir_ff, dir_in;
   logic [STEP_BITS-1:0] target_ff;

   logic signed [TGT_BITS-1:0] tgt, pos, n, half, tol, d_fwd, d_fwd_wrap, d_back, d_back_wrap;
   logic stay;

   // Advance everything while the output slot is empty or being drained.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Calibration registers: the user must write them only while the pipeline is empty; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_rev <= STEP_BITS'(2048);
         cfg_ff.middle_x      <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
         cfg_ff.middle_y      <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
         cfg_ff.dead_zone     <= DZ_BITS'(32);
         cfg_ff.noise_tol     <= STEP_BITS'(16);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_STEPS_PER_REV: cfg_ff.steps_per_rev <= csr_wdata[STEP_BITS-1:0];
            REG_MIDDLE_X:      cfg_ff.middle_x      <= csr_wdata[SAMPLE_BITS-1:0];
            REG_MIDDLE_Y:      cfg_ff.middle_y      <= csr_wdata[SAMPLE_BITS-1:0];
            REG_DEAD_ZONE:     cfg_ff.dead_zone     <= csr_wdata[DZ_BITS-1:0];
            REG_NOISE_TOL:     cfg_ff.noise_tol     <= csr_wdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Centre the sample, pick quadrant, set up dividend and divisor.
   jsd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .sample_x     (req_sample_x),
      .sample_y     (req_sample_y),
      .current_step (req_current_step),
      .cfg          (cfg_ff),
      .out          (front_out)
   );

   // Quotient and remainder of the larger over the smaller magnitude.
   jsd_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (front_out),
      .out   (div_out)
   );

   // Arctangent table, scale by the table unit, form the target.
   jsd_target u_target (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .steps_per_rev (cfg_ff.steps_per_rev),
      .in            (div_out),
      .out           (tgt_out)
   );

   // Decide stay / clockwise / counterclockwise, wrap-around included.
   always_comb begin
      tgt  = tgt_out.tgt;
      pos  = $signed({{(TGT_BITS-STEP_BITS){1'b0}}, tgt_out.ctx.pos});
      n    = $signed({{(TGT_BITS-STEP_BITS){1'b0}}, cfg_ff.steps_per_rev});
      half = n >>> 1;
      tol  = $signed({{(TGT_BITS-STEP_BITS){1'b0}}, cfg_ff.noise_tol});
      d_fwd       = tgt - pos;
      d_fwd_wrap  = pos + n - tgt;
      d_back      = pos - tgt;
      d_back_wrap = tgt + n - pos;
      if (tgt >= pos)
         stay = (d_fwd >= 0 && d_fwd < tol) || (d_fwd_wrap >= 0 && d_fwd_wrap < tol);
      else
         stay = (d_back >= 0 && d_back < tol) || (d_back_wrap >= 0 && d_back_wrap < tol);
      if (tgt_out.ctx.centred || stay)
         dir_in = DIR_STAY;
      else if ((tgt > pos && d_fwd < half) || (tgt < pos && d_back > half))
         dir_in = DIR_CW;
      else
         dir_in = DIR_CCW;
   end

   // Output register: hold while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tgt_out.valid;
      end
      if (en) begin
         dir_ff    <= dir_in;
         target_ff <= tgt[STEP_BITS-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_direction   = dir_ff;
   assign rsp_target_step = target_ff;
endmodule
`default_nettype wire

### rtl/core/jsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jsd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [1:0]                      rsp_direction,
   input wire logic [jsd_pkg::STEP_BITS-1:0]   rsp_target_step
);
   import jsd_pkg::*;

   logic unused_req;
   assign unused_req = req_valid;

   `JSD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")
   `JSD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_direction) && $stable(rsp_target_step), "stalled result changed")
   `JSD_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "input blocked with empty output")
   `JSD_ASSERT(a_dir_code, clock, reset, rsp_valid |-> (rsp_direction == DIR_STAY || rsp_direction == DIR_CW || rsp_direction == DIR_CCW), "bad direction code")
endmodule

bind joystick_to_stepper_direction jsd_checker u_jsd_checker (.*);
`default_nettype wire
